// ----- src/cmg_pkg.sv -----
// ----------------------------------------------------------------------------
// Clipmap mesh generator package
// Shared widths, mesh and operation codes, and the request context that
// travels from the front end through the queue and the divider pipelines.
// ----------------------------------------------------------------------------
package cmg_pkg;

   localparam int ARG_W       = 19;
   localparam int DIV_W       = 10;
   localparam int RES_W       = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [RES_W-1:0] TILE_RES_RESET = 8'd64;

   localparam logic [2:0] KIND_TILE   = 3'd0;
   localparam logic [2:0] KIND_FILLER = 3'd1;
   localparam logic [2:0] KIND_TRIM   = 3'd2;
   localparam logic [2:0] KIND_CROSS  = 3'd3;
   localparam logic [2:0] KIND_SEAM   = 3'd4;

   localparam logic OP_INDEX  = 1'b0;
   localparam logic OP_VERTEX = 1'b1;

   // Everything the back end needs about one request. The arg field is the
   // element for vertex reads and the pre-reversal position for index reads.
   typedef struct packed {
      logic [2:0]       kind;
      logic             vert;
      logic             oor;
      logic [ARG_W-1:0] len;
      logic [ARG_W-1:0] arg;
      logic [DIV_W-1:0] d1;
      logic [RES_W-1:0] t;
      logic [ARG_W-1:0] q1;
      logic [DIV_W-1:0] r1;
   } ctx_type;

   typedef struct packed {
      logic    valid;
      ctx_type ctx;
   } queue_type;

endpackage

// ----- src/cmg_front.sv -----
// ----------------------------------------------------------------------------
// Clipmap mesh generator front end
// Accepts requests, works out the list length, range flag, position and
// first divisor, and holds the classified requests in a short queue.
// ----------------------------------------------------------------------------
module cmg_front import cmg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_mesh_kind,
   input  logic             req_opcode,
   input  logic [ARG_W-1:0] req_element,
   input  logic [RES_W-1:0] tile_res,
   input  logic             pop,
   output queue_type        head
);

   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   ctx_type           entry_ff [QUEUE_DEPTH];
   ctx_type           cls;
   logic              push, do_pop;
   logic [8:0]        pv;
   logic [9:0]        c;
   logic [15:0]       tt;
   logic [17:0]       pv_sq;
   logic [ARG_W-1:0]  len;
   logic [DIV_W-1:0]  d1;

   assign pv    = 9'(tile_res) + 9'd1;
   assign c     = 10'({tile_res, 2'b00}) + 10'd2;
   assign tt    = 16'(tile_res) * 16'(tile_res);
   assign pv_sq = 18'(pv) * 18'(pv);

   always_comb begin
      case (req_mesh_kind)
         KIND_TILE:   len = req_opcode ? ARG_W'(pv_sq) : ARG_W'(tt) * 19'd6;
         KIND_FILLER: len = req_opcode ? ARG_W'(pv) << 3 : ARG_W'(tile_res) * 19'd24;
         KIND_TRIM:   len = req_opcode ? (ARG_W'(c) << 2) + 19'd2
                                       : ARG_W'(c) * 19'd12 - 19'd6;
         KIND_CROSS:  len = req_opcode ? ARG_W'(pv) << 3
                                       : ARG_W'(tile_res) * 19'd24 + 19'd6;
         KIND_SEAM:   len = req_opcode ? ARG_W'(c) << 2 : ARG_W'(c) * 19'd6;
         default:     len = '0;
      endcase
   end

   // Index reads use 6 (or 3 for the seam's triangles); vertex reads divide
   // by the row pitch of the mesh in question.
   always_comb begin
      if (req_opcode == OP_INDEX) begin
         d1 = (req_mesh_kind == KIND_SEAM) ? 10'd3 : 10'd6;
      end else begin
         case (req_mesh_kind)
            KIND_TILE:   d1 = DIV_W'(pv);
            KIND_FILLER: d1 = DIV_W'({pv, 1'b0});
            KIND_SEAM:   d1 = c;
            default:     d1 = 10'd1;
         endcase
      end
   end

   always_comb begin
      cls.kind = req_mesh_kind;
      cls.vert = req_opcode;
      cls.oor  = (req_element >= len);
      cls.len  = len;
      cls.arg  = req_opcode ? req_element : len - 19'd1 - req_element;
      cls.d1   = d1;
      cls.t    = tile_res;
      cls.q1   = '0;
      cls.r1   = '0;
   end

   assign req_stall  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign do_pop     = pop && head.valid;
   assign head.valid = (count_ff != '0);
   assign head.ctx   = entry_ff[rd_ptr_ff];

   assign count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   assign wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- src/cmg_div.sv -----
// ----------------------------------------------------------------------------
// Clipmap mesh generator divider
// Restoring divider, one quotient bit per pipeline stage, with the request
// context riding alongside. The whole pipe advances when enable is high.
// ----------------------------------------------------------------------------
module cmg_div import cmg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [ARG_W-1:0] in_dividend,
   input  logic [DIV_W-1:0] in_divisor,
   input  ctx_type          in_ctx,
   output logic             out_valid,
   output logic [ARG_W-1:0] out_quotient,
   output logic [DIV_W-1:0] out_remainder,
   output ctx_type          out_ctx
);

   logic             vld_ff [ARG_W];
   logic [DIV_W-1:0] rem_ff [ARG_W];
   logic [ARG_W-1:0] quo_ff [ARG_W];
   logic [ARG_W-1:0] dvd_ff [ARG_W];
   logic [DIV_W-1:0] dsr_ff [ARG_W];
   ctx_type          ctx_ff [ARG_W];

   for (genvar k = 0; k < ARG_W; k++) begin : g_stage
      logic             vld_prev;
      logic [DIV_W-1:0] rem_prev, dsr_prev, rem_in;
      logic [ARG_W-1:0] quo_prev, dvd_prev, quo_in;
      ctx_type          ctx_prev;
      logic [DIV_W:0]   rem_sh;
      logic             qbit;

      if (k == 0) begin : g_first
         assign vld_prev = in_valid;
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign dvd_prev = in_dividend;
         assign dsr_prev = in_divisor;
         assign ctx_prev = in_ctx;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign dvd_prev = dvd_ff[k-1];
         assign dsr_prev = dsr_ff[k-1];
         assign ctx_prev = ctx_ff[k-1];
      end

      assign rem_sh = {rem_prev, dvd_prev[ARG_W-1]};
      assign qbit   = (rem_sh >= {1'b0, dsr_prev});
      assign rem_in = qbit ? DIV_W'(rem_sh - {1'b0, dsr_prev}) : DIV_W'(rem_sh);
      assign quo_in = {quo_prev[ARG_W-2:0], qbit};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            dvd_ff[k] <= {dvd_prev[ARG_W-2:0], 1'b0};
            dsr_ff[k] <= dsr_prev;
            ctx_ff[k] <= ctx_prev;
         end
      end
   end

   assign out_valid     = vld_ff[ARG_W-1];
   assign out_quotient  = quo_ff[ARG_W-1];
   assign out_remainder = rem_ff[ARG_W-1];
   assign out_ctx       = ctx_ff[ARG_W-1];

endmodule

// ----- src/cmg_back.sv -----
// ----------------------------------------------------------------------------
// Clipmap mesh generator back end
// Pops classified requests, runs the two divider pipes and forms the index
// or vertex into the response register.
// ----------------------------------------------------------------------------
module cmg_back import cmg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  queue_type          head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_index_value,
   output logic signed [11:0] rsp_vertex_x_half,
   output logic signed [11:0] rsp_vertex_z_half,
   output logic [ARG_W-1:0]   rsp_list_length,
   output logic               rsp_out_of_range
);

   function automatic logic [1:0] fill_even(input logic [2:0] r);
      case (r)
         3'd0:    fill_even = 2'd1;
         3'd2:    fill_even = 2'd3;
         3'd4:    fill_even = 2'd2;
         3'd5:    fill_even = 2'd3;
         default: fill_even = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] fill_odd(input logic [2:0] r);
      case (r)
         3'd0:    fill_odd = 2'd1;
         3'd2:    fill_odd = 2'd2;
         3'd3:    fill_odd = 2'd1;
         3'd4:    fill_odd = 2'd2;
         3'd5:    fill_odd = 2'd3;
         default: fill_odd = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] trim_tab(input logic [2:0] r);
      case (r)
         3'd0:    trim_tab = 2'd1;
         3'd2:    trim_tab = 2'd2;
         3'd3:    trim_tab = 2'd3;
         3'd4:    trim_tab = 2'd1;
         3'd5:    trim_tab = 2'd2;
         default: trim_tab = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] vert_tab(input logic [2:0] r);
      case (r)
         3'd0:    vert_tab = 2'd1;
         3'd1:    vert_tab = 2'd3;
         3'd4:    vert_tab = 2'd3;
         3'd5:    vert_tab = 2'd2;
         default: vert_tab = 2'd0;
      endcase
   endfunction

   logic             enable;
   logic             v1, v2;
   logic [ARG_W-1:0] q1, q2;
   logic [DIV_W-1:0] r1, r2, d2;
   ctx_type          c1, c2_in, cx;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      idx_ff, idx_in;
   logic [11:0]      xh_ff, xh_in, zh_ff, zh_in;
   logic [ARG_W-1:0] len_ff;
   logic             oor_ff;

   assign enable = !rsp_valid_ff || !rsp_stall;
   assign pop    = enable && head.valid;

   cmg_div u_div1 (
      .clock         (clock),
      .reset         (reset),
      .enable        (enable),
      .in_valid      (pop),
      .in_dividend   (head.ctx.arg),
      .in_divisor    (head.ctx.d1),
      .in_ctx        (head.ctx),
      .out_valid     (v1),
      .out_quotient  (q1),
      .out_remainder (r1),
      .out_ctx       (c1)
   );

   // The second divide splits the quad number of tile and filler index
   // reads by the tile resolution.
   always_comb begin
      c2_in    = c1;
      c2_in.q1 = q1;
      c2_in.r1 = r1;
      if (c1.vert == OP_INDEX &&
          (c1.kind == KIND_TILE || c1.kind == KIND_FILLER)) begin
         d2 = DIV_W'(c1.t);
      end else begin
         d2 = 10'd1;
      end
   end

   cmg_div u_div2 (
      .clock         (clock),
      .reset         (reset),
      .enable        (enable),
      .in_valid      (v1),
      .in_dividend   (q1),
      .in_divisor    (d2),
      .in_ctx        (c2_in),
      .out_valid     (v2),
      .out_quotient  (q2),
      .out_remainder (r2),
      .out_ctx       (cx)
   );

   // Final element formation. All coordinate math is 14-bit two's complement.
   logic [8:0]       pv;
   logic [9:0]       c;
   logic [2:0]       r6;
   logic             dx, dy;
   logic [8:0]       y1;
   logic [17:0]      tile_idx;
   logic [ARG_W-1:0] q, k, ci, h, tri_base, first, j, e;
   logic [13:0]      xs, zs, ti, wi, ws, cc;
   logic             is_trim;

   always_comb begin
      pv       = 9'(cx.t) + 9'd1;
      c        = 10'({cx.t, 2'b00}) + 10'd2;
      r6       = cx.r1[2:0];
      q        = cx.q1;
      e        = cx.arg;
      dx       = (r6 == 3'd1 || r6 == 3'd4 || r6 == 3'd5);
      dy       = (r6 == 3'd1 || r6 == 3'd2 || r6 == 3'd5);
      y1       = 9'(q2[7:0]) + 9'(dy);
      tile_idx = 18'(y1) * 18'(pv) + 18'(r2[7:0]) + 18'(dx);
      h        = ARG_W'({cx.t, 1'b1});
      k        = q - h;
      ci       = (k < ARG_W'(cx.t)) ? k : k + 19'd1;
      tri_base = ARG_W'({q[ARG_W-2:0], 1'b0});
      first    = ARG_W'({c, 1'b0}) + 19'd2;
      j        = e - first;
      ti       = 14'(cx.t);
      cc       = 14'(c);
      wi       = 14'(cx.r1[DIV_W-1:1]);
      ws       = 14'(cx.r1[0]);
      is_trim  = 1'b0;
      idx_in   = '0;
      xs       = '0;
      zs       = '0;

      if (cx.vert == OP_INDEX) begin
         case (cx.kind)
            KIND_TILE: begin
               idx_in = 16'(tile_idx);
            end
            KIND_FILLER: begin
               idx_in = 16'({q + q2, 1'b0}) +
                        16'(q2[0] ? fill_odd(r6) : fill_even(r6));
            end
            KIND_TRIM: begin
               if (q >= ARG_W'(c)) begin
                  idx_in = 16'({c, 1'b0}) + 16'd2 + 16'({q - ARG_W'(c), 1'b0}) +
                           16'(trim_tab(r6));
               end else begin
                  idx_in = 16'({q, 1'b0}) + 16'(trim_tab(r6));
               end
            end
            KIND_CROSS: begin
               if (q < h) begin
                  idx_in = 16'({q, 1'b0}) + 16'(fill_even(r6));
               end else begin
                  idx_in = 16'({pv, 2'b00}) + 16'({ci, 1'b0}) + 16'(vert_tab(r6));
               end
            end
            KIND_SEAM: begin
               if (e == ARG_W'(c) * 19'd6 - 19'd1) begin
                  idx_in = '0;
               end else begin
                  case (cx.r1[1:0])
                     2'd0:    idx_in = 16'(tri_base) + 16'd1;
                     2'd1:    idx_in = 16'(tri_base);
                     default: idx_in = 16'(tri_base) + 16'd2;
                  endcase
               end
            end
            default: idx_in = '0;
         endcase
      end else begin
         case (cx.kind)
            KIND_TILE: begin
               xs = 14'(cx.r1);
               zs = 14'(q);
            end
            KIND_FILLER: begin
               case (q[1:0])
                  2'd0: begin
                     xs = ti + wi + 14'd1;
                     zs = ws;
                  end
                  2'd1: begin
                     xs = 14'd1 - ws;
                     zs = ti + wi + 14'd1;
                  end
                  2'd2: begin
                     xs = 14'd0 - (ti + wi);
                     zs = 14'd1 - ws;
                  end
                  default: begin
                     xs = ws;
                     zs = 14'd0 - (ti + wi);
                  end
               endcase
            end
            KIND_TRIM: begin
               is_trim = 1'b1;
               if (e < first) begin
                  xs = 14'(e[0]);
                  zs = cc - 14'(e[ARG_W-1:1]);
               end else begin
                  xs = 14'(j[ARG_W-1:1]) + 14'd1;
                  zs = 14'(j[0]);
               end
            end
            KIND_CROSS: begin
               if (e < ARG_W'({pv, 2'b00})) begin
                  xs = 14'(e[ARG_W-1:1]) - ti;
                  zs = 14'(e[0]);
               end else begin
                  xs = 14'(k[0]);
                  zs = 14'(k[ARG_W-1:1]) - ti;
               end
               if (e >= ARG_W'({pv, 2'b00})) begin
                  xs = 14'(e[0]);
                  zs = 14'((e - ARG_W'({pv, 2'b00})) >> 1) - ti;
               end
            end
            KIND_SEAM: begin
               case (q[1:0])
                  2'd0: begin
                     xs = 14'(cx.r1);
                     zs = '0;
                  end
                  2'd1: begin
                     xs = cc;
                     zs = 14'(cx.r1);
                  end
                  2'd2: begin
                     xs = cc - 14'(cx.r1);
                     zs = cc;
                  end
                  default: begin
                     xs = '0;
                     zs = cc - 14'(cx.r1);
                  end
               endcase
            end
            default: begin
               xs = '0;
               zs = '0;
            end
         endcase
      end

      xh_in = 12'({xs[12:0], 1'b0} - (is_trim ? cc + 14'd1 : 14'd0));
      zh_in = 12'({zs[12:0], 1'b0} - (is_trim ? cc + 14'd1 : 14'd0));

      if (cx.oor) begin
         idx_in = '0;
         xh_in  = '0;
         zh_in  = '0;
      end
   end

   assign rsp_valid_in = enable ? v2 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         idx_ff <= idx_in;
         xh_ff  <= xh_in;
         zh_ff  <= zh_in;
         len_ff <= cx.len;
         oor_ff <= cx.oor;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_index_value   = idx_ff;
   assign rsp_vertex_x_half = $signed(xh_ff);
   assign rsp_vertex_z_half = $signed(zh_ff);
   assign rsp_list_length   = len_ff;
   assign rsp_out_of_range  = oor_ff;

endmodule

// ----- src/clipmap_mesh_element_generator_top.sv -----
// ----------------------------------------------------------------------------
// Clipmap mesh element generator
// Returns one element of the tile, filler, trim, cross or seam mesh of a
// geometry clipmap, with its list length and a range flag.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Carries
//   req_      in         valid / stall      mesh kind, opcode, element
//   rsp_      out        valid / stall      index, x and z in half units,
//                                           list length, out-of-range flag
//   csr_      in         valid / ready      tile resolution (8 bits)
//
// One request is taken per clock cycle while the queue is not full. An
// accepted request is registered in the queue, then passes the 19 stages of
// each of the two bit-per-stage divider pipes and the output stage into the
// response register.
// Reset is synchronous and leaves the resolution at 64 with the queue empty;
// no clearing pass is needed. A response stall freezes the back end only; the
// four-entry queue keeps taking requests until it fills.
//
// The front end classifies each request: it computes the list length from the
// resolution, flags positions past the end and turns index reads into their
// position in the unreversed list. The back end divides that position first by
// the row pitch of the mesh (or by six, or three on the seam, for triangles) and,
// for tile and filler index lists, by the resolution, then forms the final element.
module clipmap_mesh_element_generator_top import cmg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mesh_kind,
   input  logic               req_opcode,
   input  logic [ARG_W-1:0]   req_element,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_index_value,
   output logic signed [11:0] rsp_vertex_x_half,
   output logic signed [11:0] rsp_vertex_z_half,
   output logic [ARG_W-1:0]   rsp_list_length,
   output logic               rsp_out_of_range,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [RES_W-1:0]   csr_data
);

   logic [RES_W-1:0] tile_res_ff, tile_res_in;
   queue_type        head;
   logic             pop;

   // The resolution register is always writable; the user must write it only while
   // the block is idle, which the block itself does not enforce.
   assign csr_ready   = 1'b1;
   assign tile_res_in = (csr_valid && csr_ready) ? csr_data : tile_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_res_ff <= TILE_RES_RESET;
      end else begin
         tile_res_ff <= tile_res_in;
      end
   end

   cmg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mesh_kind (req_mesh_kind),
      .req_opcode    (req_opcode),
      .req_element   (req_element),
      .tile_res      (tile_res_ff),
      .pop           (pop),
      .head          (head)
   );

   cmg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_index_value   (rsp_index_value),
      .rsp_vertex_x_half (rsp_vertex_x_half),
      .rsp_vertex_z_half (rsp_vertex_z_half),
      .rsp_list_length   (rsp_list_length),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule
